>>> src/hts_pkg.sv
// Package for the height-field triangle sampler.
// Holds the field widths, the tile constants, the register indexes and the action codes.
// No dependencies.
package hts_pkg;

  localparam int TERRAIN_SIZE = 1024;
  localparam int MAX_EDGE     = 256;
  localparam int SPAN_Q8      = TERRAIN_SIZE * 256;
  localparam int POS_W        = $clog2(SPAN_Q8);
  localparam int ADDR_W       = 16;
  localparam int STORE_DEPTH  = 1 << ADDR_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

>>> src/hts_req_if.sv
// Request channel of the height-field sampler: loads and queries.
// Depends on hts_pkg for the address width.
interface hts_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [hts_pkg::ADDR_W-1:0] sample_index;
  logic [7:0]                 sample_value;
  logic signed [31:0]         pos_x;
  logic signed [31:0]         pos_z;
  logic                       world_coords;

  modport source (output valid, action, sample_index, sample_value, pos_x, pos_z,
                  world_coords, input ready);
  modport sink (input valid, action, sample_index, sample_value, pos_x, pos_z,
                world_coords, output ready);
endinterface

>>> src/hts_rsp_if.sv
// Response channel of the height-field sampler: one height per query.
// No dependencies.
interface hts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] height;

  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

>>> src/hts_cfg_if.sv
// Configuration write channel of the height-field sampler.
// Depends on hts_pkg for index and data widths.
interface hts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hts_pkg::CFG_IDX_W-1:0]  index;
  logic [hts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/heightfield_triangle_sampler_core.sv
// Height-field triangle sampler: height store, query sequencer and scaling.
// Depends on hts_pkg, hts_req_if, hts_rsp_if and hts_cfg_if.
//
//  channel | role  | moves
//  req     | sink  | one load (store write) or one query per transfer
//  rsp     | source| one height per query
//  cfg     | sink  | one register write per transfer
//
// A load writes the store at its transfer and the sampler stays idle. A query holds
// the input until it is done: the transfer, position split, base address, the
// read states RD0 to RD4 for four reads through the single store port and its
// registered read, interpolation, one product, the divide by 255 as a reciprocal
// multiply and the final add. Reset is synchronous, clears control and sets the
// configuration registers to their defaults; the store is not cleared. A finished
// height waits in the output register; a new item is taken meanwhile, and a
// following query stalls only at its final step.
module heightfield_triangle_sampler_core (
  input  logic       clk,
  input  logic       rst,
  hts_req_if.sink    req,
  hts_rsp_if.source  rsp,
  hts_cfg_if.sink    cfg
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOC  = 4'd1;
  localparam logic [3:0] S_BASE = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_RD3  = 4'd6;
  localparam logic [3:0] S_RD4  = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam int PW = hts_pkg::POS_W;
  localparam int AW = hts_pkg::ADDR_W;

  logic [3:0] state;

  logic signed [10:0] origin_x;
  logic signed [10:0] origin_z;
  logic [8:0]         edge_count;
  logic signed [23:0] min_height;
  logic signed [23:0] max_height;

  logic [7:0] store [hts_pkg::STORE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic [PW-1:0] pcx, pcz;
  logic [7:0]    cx, cz;
  logic [15:0]   fx, fz;
  logic [AW-1:0] base;
  logic [7:0]    y0, y1, y2, y3;
  logic [23:0]   r;
  logic          neg;
  logic [31:0]   dv;
  logic          out_valid;
  logic signed [23:0] out_height;

  // Effective edge count and cell count.
  logic [8:0] n;
  logic [7:0] nm1;
  always_comb begin
    if (edge_count < 9'd2) n = 9'd2;
    else if (edge_count > 9'(hts_pkg::MAX_EDGE)) n = 9'(hts_pkg::MAX_EDGE);
    else n = edge_count;
  end
  assign nm1 = 8'(n - 9'd1);

  // Local position with optional origin subtract and clamp to the tile.
  function automatic logic [PW-1:0] clamp_pos(input logic signed [31:0] p,
                                              input logic signed [10:0] org,
                                              input logic world);
    logic signed [33:0] s;
    logic signed [33:0] off;
    off = world ? (34'(org) <<< PW) : 34'sd0;
    s = 34'(p) - off;
    if (s < 0) clamp_pos = '0;
    else if (s > 34'(hts_pkg::SPAN_Q8 - 1)) clamp_pos = PW'(hts_pkg::SPAN_Q8 - 1);
    else clamp_pos = s[PW-1:0];
  endfunction

  logic in_xfer, cfg_xfer;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_xfer   = req.valid && req.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_z   <= '0;
      edge_count <= 9'(hts_pkg::MAX_EDGE);
      min_height <= '0;
      max_height <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg.index)
        hts_pkg::REG_ORIGIN_X: origin_x   <= cfg.data[10:0];
        hts_pkg::REG_ORIGIN_Z: origin_z   <= cfg.data[10:0];
        hts_pkg::REG_EDGE:     edge_count <= cfg.data[8:0];
        hts_pkg::REG_MIN:      min_height <= cfg.data;
        hts_pkg::REG_MAX:      max_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Height store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (in_xfer && req.action == hts_pkg::ACT_LOAD) begin
      store[req.sample_index] <= req.sample_value;
    end
    rd_data <= store[rd_addr];
  end

  // The fourth corner arrives in S_INT and is used straight from the read port;
  // no load can reach the store while a query is in flight.
  assign y3 = rd_data;

  // Cell split: t = p * (n - 1); cell is t / span, fraction is the rest in Q0.16.
  logic [PW+7:0] tx, tz;
  assign tx = (PW+8)'(pcx) * (PW+8)'(nm1);
  assign tz = (PW+8)'(pcz) * (PW+8)'(nm1);

  // Triangle select and interpolation operands.
  logic              upper;
  logic [16:0]       ma, mb;
  logic [7:0]        yb;
  logic signed [8:0] da, db;
  logic signed [25:0] rs;
  assign upper = (17'(fx) + 17'(fz)) <= 17'd65536;
  always_comb begin
    if (upper) begin
      ma = 17'(fx);
      mb = 17'(fz);
      yb = y0;
      da = $signed({1'b0, y1}) - $signed({1'b0, y0});
      db = $signed({1'b0, y2}) - $signed({1'b0, y0});
    end else begin
      ma = 17'd65536 - 17'(fx);
      mb = 17'd65536 - 17'(fz);
      yb = y3;
      da = $signed({1'b0, y2}) - $signed({1'b0, y3});
      db = $signed({1'b0, y1}) - $signed({1'b0, y3});
    end
    rs = $signed({2'b00, yb, 16'h0000}) + $signed({1'b0, ma}) * 26'(da)
         + $signed({1'b0, mb}) * 26'(db);
  end

  // Scale span and its magnitude.
  logic signed [24:0] span;
  logic [23:0]        span_abs;
  assign span     = 25'(max_height) - 25'(min_height);
  assign span_abs = span[24] ? 24'(-span) : span[23:0];

  logic [47:0] prod;
  assign prod = 48'(r) * 48'(span_abs);

  // Divide by 255 as a multiply by the rounded-up reciprocal 2^39/255; the
  // rounding error is small enough to be exact for every 32-bit dividend.
  logic [63:0] recip;
  assign recip = 64'(dv) * 64'(32'h80808081);

  logic signed [25:0] hsum;
  assign hsum = 26'(min_height) + (neg ? -$signed({1'b0, dv[24:0]})
                                        : $signed({1'b0, dv[24:0]}));

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_xfer && req.action == hts_pkg::ACT_QUERY) state <= S_LOC;
        S_LOC:  state <= S_BASE;
        S_BASE: state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_RD3;
        S_RD3:  state <= S_RD4;
        S_RD4:  state <= S_INT;
        S_INT:  state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pcx <= clamp_pos(req.pos_x, origin_x, req.world_coords);
      pcz <= clamp_pos(req.pos_z, origin_z, req.world_coords);
    end
    case (state)
      S_LOC: begin
        cx <= tx[PW+7:PW];
        cz <= tz[PW+7:PW];
        fx <= tx[PW-1:PW-16];
        fz <= tz[PW-1:PW-16];
      end
      S_BASE: begin
        base    <= AW'(17'(cz) * 17'(n) + 17'(cx));
      end
      S_RD0: rd_addr <= base;
      S_RD1: rd_addr <= base + AW'(1);
      S_RD2: begin
        y0      <= rd_data;
        rd_addr <= base + AW'(n);
      end
      S_RD3: begin
        y1      <= rd_data;
        rd_addr <= base + AW'(n) + AW'(1);
      end
      S_RD4: y2 <= rd_data;
      S_INT: r  <= rs[23:0];
      S_MUL: begin
        dv  <= prod[47:16];
        neg <= span[24];
      end
      S_DIV: dv <= 32'(recip[63:39]);
      S_DONE: if (out_free) out_height <= hsum[23:0];
      default: ;
    endcase
  end

  assign rsp.valid  = out_valid;
  assign rsp.height = out_height;

  property p_query_starts;
    @(posedge clk) disable iff (rst)
      (in_xfer && req.action == hts_pkg::ACT_QUERY) |=> (state == S_LOC);
  endproperty
  a_query_starts: assert property (p_query_starts) else $error("query did not start");

  property p_cell_in_range;
    @(posedge clk) disable iff (rst)
      (state == S_BASE) |-> (cx < nm1 && cz < nm1);
  endproperty
  a_cell_in_range: assert property (p_cell_in_range) else $error("cell out of range");

  property p_rsp_from_done;
    @(posedge clk) disable iff (rst)
      $rose(rsp.valid) |-> ($past(state) == S_DONE);
  endproperty
  a_rsp_from_done: assert property (p_rsp_from_done) else $error("stray response");

endmodule
